>>> hw/rtl/rpsa_pkg.sv
// Shared constants, codes and types of the random-probe slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package rpsa_pkg;

	localparam int NUM_BINS      = 64;
	localparam int SLOTS_PER_BIN = 16;
	localparam int RANDOM_TRIES  = 100;

	localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int SLOT_W = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;
	localparam int TRY_W  = (RANDOM_TRIES > 1) ? $clog2(RANDOM_TRIES) : 1;
	localparam int LAST_TRY  = (RANDOM_TRIES > 0) ? RANDOM_TRIES - 1 : 0;
	localparam int LAST_SLOT = SLOTS_PER_BIN - 1;

	// xorshift32 shift amounts
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic [31:0] SEED_RESET = 32'd1;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;

	typedef enum logic [1:0] {
		STAT_ACQUIRED = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_CLEARED  = 2'd3
	} status_t;

	typedef struct packed {
		logic                     rd_en;
		logic                     wr_en;
		logic                     clr;
		logic [BIN_W-1:0]         addr;
		logic [SLOTS_PER_BIN-1:0] wr_row;
	} map_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/random_probe_slot_allocator.sv
// Top level of the random-probe slot allocator: sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Slot allocator over 64 bins of 16 slots. A command is taken when start is
// high and busy is low. An acquire reads the bin's row, then makes up to 100
// random guesses (one xorshift32 step per cycle, low 4 bits pick the slot)
// and, if all hit taken slots, scans the 16 slots linearly from the last
// guess. The first free slot is claimed and written back. The result appears
// on status, bin_out and slot_index, marked by done for exactly one cycle;
// the receiver cannot stall it, so sample it on that cycle. Clear and
// out-of-range commands give done in the cycle after acceptance; an acquire
// keeps busy high through the row read, up to 100 guesses and, only when all
// guesses fail, up to 16 scan steps, at one probe per cycle through the
// single row check. Done rises in the first cycle that busy is low again. Clear
// empties every bin through per-row valid bits; no clearing pass follows reset.
// The seed is written on cfg_data/cfg_valid while busy is low and reloads
// the generator at once.
module random_probe_slot_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [7:0]  bin_index,
	output logic             done,
	output logic      [1:0]  status,
	output logic      [7:0]  bin_out,
	output logic      [3:0]  slot_index,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import rpsa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_RAND = 4'b0100,
		ST_SCAN = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [7:0]               bin_q;
	logic [TRY_W-1:0]         try_q;
	logic [SLOT_W-1:0]        idx_q;
	logic [SLOT_W-1:0]        scan_q;
	logic                     done_q;
	status_t                  status_q;
	logic [3:0]               slot_q;

	logic                     accept;
	logic                     in_range;
	logic                     rng_step;
	logic                     cfg_load;
	logic [31:0]              rng_next;
	logic [SLOT_W-1:0]        idx_rand;
	logic [SLOT_W-1:0]        probe_idx;
	logic                     probe_free;
	logic                     claim;
	logic [SLOTS_PER_BIN-1:0] rd_row;
	map_cmd_t                 map_cmd;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_load  = cfg_valid && cfg_ready;
	assign in_range  = ({1'b0, bin_index} < 9'(NUM_BINS));

	// Random guess: the slot count is a power of two, so the remainder is a mask.
	assign idx_rand   = rng_next[SLOT_W-1:0];
	assign probe_idx  = (state_q == ST_RAND) ? idx_rand : idx_q;
	assign probe_free = !rd_row[probe_idx];
	assign claim      = ((state_q == ST_RAND) || (state_q == ST_SCAN)) && probe_free;
	assign rng_step   = (state_q == ST_RAND);

	always_comb begin
		map_cmd        = '0;
		map_cmd.rd_en  = (state_q == ST_READ);
		map_cmd.wr_en  = claim;
		map_cmd.clr    = accept && (req_type == REQ_CLEAR);
		map_cmd.addr   = bin_q[BIN_W-1:0];
		map_cmd.wr_row = rd_row | (SLOTS_PER_BIN'(1) << probe_idx);
	end

	rpsa_rng u_rng (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cfg_load),
		.seed      (cfg_data),
		.step      (rng_step),
		.next_word (rng_next)
	);

	rpsa_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.rd_row (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bin_q    <= '0;
			try_q    <= '0;
			idx_q    <= '0;
			scan_q   <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_ACQUIRED;
			slot_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bin_q <= bin_index;
						if (req_type == REQ_CLEAR) begin
							done_q   <= 1'b1;
							status_q <= STAT_CLEARED;
							slot_q   <= '0;
						end else if (!in_range) begin
							done_q   <= 1'b1;
							status_q <= STAT_RANGE;
							slot_q   <= '0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// Row is in the read register next cycle; start the probes.
					try_q   <= '0;
					idx_q   <= '0;
					scan_q  <= '0;
					state_q <= (RANDOM_TRIES == 0) ? ST_SCAN : ST_RAND;
				end
				ST_RAND: begin
					if (probe_free) begin
						done_q   <= 1'b1;
						status_q <= STAT_ACQUIRED;
						slot_q   <= 4'(idx_rand);
						state_q  <= ST_IDLE;
					end else if (try_q == TRY_W'(LAST_TRY)) begin
						// Guesses exhausted: scan from the last guess.
						idx_q   <= idx_rand;
						state_q <= ST_SCAN;
					end else begin
						try_q <= TRY_W'(try_q + 1'b1);
					end
				end
				ST_SCAN: begin
					if (probe_free) begin
						done_q   <= 1'b1;
						status_q <= STAT_ACQUIRED;
						slot_q   <= 4'(idx_q);
						state_q  <= ST_IDLE;
					end else if (scan_q == SLOT_W'(LAST_SLOT)) begin
						done_q   <= 1'b1;
						status_q <= STAT_FULL;
						slot_q   <= '0;
						state_q  <= ST_IDLE;
					end else begin
						scan_q <= SLOT_W'(scan_q + 1'b1);
						// Advance with wrap inside the bin.
						idx_q  <= (idx_q == SLOT_W'(LAST_SLOT)) ? '0 : SLOT_W'(idx_q + 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign bin_out    = bin_q;
	assign slot_index = slot_q;

endmodule
`default_nettype wire

>>> hw/rtl/rpsa_rng.sv
// xorshift32 generator, loaded from the seed word and stepped once per guess.
`timescale 1ns / 1ps
`default_nettype none
module rpsa_rng (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [31:0] seed,
	input  wire logic        step,
	output logic      [31:0] next_word
);
	import rpsa_pkg::*;

	logic [31:0] word_q;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		t1        = word_q ^ (word_q << XS_A);
		t2        = t1 ^ (t1 >> XS_B);
		next_word = t2 ^ (t2 << XS_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= SEED_RESET;
		end else if (load) begin
			word_q <= seed;
		end else if (step) begin
			word_q <= next_word;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rpsa_map.sv
// Occupancy memory: one row of slot bits per bin, with a valid bit per row.
`timescale 1ns / 1ps
`default_nettype none
module rpsa_map (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire rpsa_pkg::map_cmd_t                 cmd,
	output logic [rpsa_pkg::SLOTS_PER_BIN-1:0]      rd_row
);
	import rpsa_pkg::*;

	logic [SLOTS_PER_BIN-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]      row_valid_q;
	logic [SLOTS_PER_BIN-1:0] rd_data_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.addr] <= cmd.wr_row;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.addr];
		end
	end

	// Clear drops every valid bit at once; a row never written reads as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				row_valid_q <= '0;
			end else if (cmd.wr_en) begin
				row_valid_q[cmd.addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= row_valid_q[cmd.addr];
			end
		end
	end

	assign rd_row = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire
